// File: rtl/hmng_pkg.sv
// Shared types and constants for the heightmap normal generator.
package hmng_pkg;

  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned ColBits    = $clog2(MaxColumns);
  localparam int unsigned SampleBits = 16;

  localparam logic [3:0] AddrGridColumns = 4'h0;
  localparam logic [3:0] AddrGridRows    = 4'h4;
  localparam logic [3:0] AddrGridSpacing = 4'h8;

  localparam logic [10:0] ColumnsReset = 11'd256;
  localparam logic [15:0] RowsReset    = 16'd256;
  localparam logic [24:0] SpacingReset = 25'd16777216;

  typedef struct packed {
    logic                  cmd;
    logic [SampleBits-1:0] height_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        out_row;
    logic [ColBits-1:0] out_col;
    logic               last_of_frame;
  } out_t;

  // Operands handed to the normal unit.
  typedef struct packed {
    logic [SampleBits-1:0] up;
    logic [SampleBits-1:0] down;
    logic [SampleBits-1:0] left;
    logic [SampleBits-1:0] right;
    logic [24:0]           spacing;
  } norm_req_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic [14:0]        y;
    logic signed [15:0] z;
  } norm_res_t;

endpackage

// File: rtl/hmng_norm_unit.sv
// Iterative unit forming the Q1.15 unit normal from four neighbour heights.
module hmng_norm_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  hmng_pkg::norm_req_t   req_i,
  output logic                  done_o,
  output hmng_pkg::norm_res_t   res_o
);

  typedef enum logic [5:0] {
    U_IDLE = 6'b000001,
    U_NORM = 6'b000010,
    U_SQ   = 6'b000100,
    U_SQRT = 6'b001000,
    U_DIV  = 6'b010000,
    U_DONE = 6'b100000
  } ustate_e;

  ustate_e state_q, state_d;

  logic [25:0] raw_q [3];
  logic [19:0] a_q [3];
  logic        neg_x_q, neg_z_q;
  logic [1:0]  sq_cnt_q;
  logic [39:0] prod_q;
  logic [41:0] acc_q;
  logic [61:0] n_q;
  logic [62:0] res_q;
  logic [4:0]  it_q;
  logic [3:0]  dj_q;
  logic [46:0] rem_q [3];
  logic [15:0] quo_q [3];

  logic [25:0] mx;
  logic [2:0]  shamt;
  logic [62:0] sq_bit;
  logic [62:0] sq_try;
  logic [46:0] dvs;
  logic [15:0] qs [3];

  always_comb begin
    mx = raw_q[0];
    if (raw_q[1] > mx) mx = raw_q[1];
    if (raw_q[2] > mx) mx = raw_q[2];
    priority if (mx[25]) shamt = 3'd6;
    else if (mx[24]) shamt = 3'd5;
    else if (mx[23]) shamt = 3'd4;
    else if (mx[22]) shamt = 3'd3;
    else if (mx[21]) shamt = 3'd2;
    else if (mx[20]) shamt = 3'd1;
    else shamt = 3'd0;
  end

  assign sq_bit = 63'd1 << {it_q, 1'b0};
  assign sq_try = res_q + sq_bit;
  assign dvs    = 47'(res_q[31:0]) << dj_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: if (start_i) state_d = U_NORM;
      U_NORM: state_d = U_SQ;
      U_SQ:   if (sq_cnt_q == 2'd3) state_d = U_SQRT;
      U_SQRT: if (it_q == 5'd0) state_d = U_DIV;
      U_DIV:  if (dj_q == 4'd0) state_d = U_DONE;
      U_DONE: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          raw_q[0] <= (req_i.right > req_i.left) ? 26'(req_i.right - req_i.left)
                                                 : 26'(req_i.left - req_i.right);
          raw_q[1] <= {req_i.spacing, 1'b0};
          raw_q[2] <= (req_i.up > req_i.down) ? 26'(req_i.up - req_i.down)
                                              : 26'(req_i.down - req_i.up);
          neg_x_q  <= req_i.right > req_i.left;
          neg_z_q  <= req_i.up > req_i.down;
        end
      end
      U_NORM: begin
        for (int i = 0; i < 3; i++) a_q[i] <= 20'(raw_q[i] >> shamt);
        sq_cnt_q <= 2'd0;
        acc_q    <= '0;
      end
      U_SQ: begin
        sq_cnt_q <= sq_cnt_q + 2'd1;
        if (sq_cnt_q != 2'd3) prod_q <= a_q[sq_cnt_q] * a_q[sq_cnt_q];
        if (sq_cnt_q != 2'd0) acc_q <= acc_q + 42'(prod_q);
        if (sq_cnt_q == 2'd3) begin
          n_q   <= {acc_q + 42'(prod_q), 20'd0};
          res_q <= '0;
          it_q  <= 5'd31;
        end
      end
      U_SQRT: begin
        if ({1'b0, n_q} >= sq_try) begin
          n_q   <= 62'({1'b0, n_q} - sq_try);
          res_q <= (res_q >> 1) + sq_bit;
        end else begin
          res_q <= res_q >> 1;
        end
        it_q <= it_q - 5'd1;
        if (it_q == 5'd0) begin
          dj_q <= 4'd15;
          for (int i = 0; i < 3; i++) begin
            rem_q[i] <= {2'b0, a_q[i], 25'd0} + 47'(res_q[31:2]);
            quo_q[i] <= '0;
          end
        end
      end
      U_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= dvs) begin
            rem_q[i]       <= rem_q[i] - dvs;
            quo_q[i][dj_q] <= 1'b1;
          end
        end
        dj_q <= dj_q - 4'd1;
      end
      U_DONE: ;
      default: ;
    endcase
  end

  // In the last square root step res_q is not yet halved, so R/2 is res_q[31:2]
  // there: the final result is res_q >> 1 and its half is res_q >> 2.
  always_comb begin
    for (int i = 0; i < 3; i++) qs[i] = quo_q[i][15] ? 16'd32767 : quo_q[i];
  end

  assign done_o   = state_q == U_DONE;
  assign res_o.x  = neg_x_q ? 16'(~qs[0] + 16'd1) : qs[0];
  assign res_o.y  = qs[1][14:0];
  assign res_o.z  = neg_z_q ? 16'(~qs[2] + 16'd1) : qs[2];

endmodule

// File: rtl/heightmap_normal_generator.sv
// Top level of the heightmap normal generator: row stores, sequencer and registers.
//
//   Channel   Direction  Handshake            Payload
//   in        to block   in_valid/in_ready    hmng_pkg::in_t (cmd, height_sample)
//   out       from block out_valid/out_ready  hmng_pkg::out_t (normal, row, col, last)
//   apb       to block   psel/penable/pready  grid_columns, grid_rows, grid_spacing
//
// A sample in the first row of a frame, or an ignored transaction, leaves the sequencer idle.
// A transaction that yields a normal goes through three row store reads, then the normal
// unit with its 32-step square root and 16-step divider, before the next can be accepted.
// Reset clears the counters, the sequencer and the output register; the row stores
// are not cleared, as every entry is written before it is read within a frame.
// A finished normal waits in the output register while the next transaction is
// taken; the sequencer only stalls if that register is still full when it finishes.
module heightmap_normal_generator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hmng_pkg::in_t        in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hmng_pkg::out_t       out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned CB = hmng_pkg::ColBits;
  localparam int unsigned SB = hmng_pkg::SampleBits;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RD1  = 7'b0000010,
    ST_RD2  = 7'b0000100,
    ST_RD3  = 7'b0001000,
    ST_CALC = 7'b0010000,
    ST_WAIT = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [10:0] cols_cfg_q;
  logic [15:0] rows_cfg_q;
  logic [24:0] spacing_cfg_q;

  // Frame position.
  logic [CB-1:0] col_q;
  logic [15:0]   row_q;
  logic [10:0]   drain_col_q;
  logic          draining_q;

  // Context of the transaction in flight.
  logic          drain_mode_q;
  logic [CB-1:0] c_q;
  logic [SB-1:0] sample_q;
  logic [15:0]   tag_row_q;
  logic          tag_last_q;
  logic          has_left_q, has_right_q, use_up_q;
  logic [SB-1:0] ctr_q, upv_q, left_q, right_q;

  // Output register.
  logic           out_valid_q;
  hmng_pkg::out_t out_q;

  // Row stores.
  logic [SB-1:0] mid_mem [hmng_pkg::MaxColumns];
  logic [SB-1:0] up_mem  [hmng_pkg::MaxColumns];
  logic [SB-1:0] mid_rd_q, up_rd_q;
  logic [CB-1:0] mid_ra, up_ra, mid_wa;
  logic          mid_we, up_we;
  logic [SB-1:0] mid_wd;

  logic [10:0] cols;
  logic [15:0] rows;
  logic [24:0] spacing;
  logic        accept, cfg_wr;
  logic        norm_done;
  hmng_pkg::norm_req_t norm_req;
  hmng_pkg::norm_res_t norm_res;

  // Registers are used clamped to their legal ranges.
  always_comb begin
    cols = cols_cfg_q;
    if (cols_cfg_q < 11'd2) cols = 11'd2;
    if (cols_cfg_q > 11'(hmng_pkg::MaxColumns)) cols = 11'(hmng_pkg::MaxColumns);
    rows    = (rows_cfg_q < 16'd2) ? 16'd2 : rows_cfg_q;
    spacing = (spacing_cfg_q == 25'd0) ? 25'd1 : spacing_cfg_q;
  end

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (paddr)
      hmng_pkg::AddrGridColumns: prdata = 32'(cols_cfg_q);
      hmng_pkg::AddrGridRows:    prdata = 32'(rows_cfg_q);
      hmng_pkg::AddrGridSpacing: prdata = 32'(spacing_cfg_q);
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q    <= hmng_pkg::ColumnsReset;
      rows_cfg_q    <= hmng_pkg::RowsReset;
      spacing_cfg_q <= hmng_pkg::SpacingReset;
    end else if (cfg_wr) begin
      unique case (paddr)
        hmng_pkg::AddrGridColumns: cols_cfg_q    <= pwdata[10:0];
        hmng_pkg::AddrGridRows:    rows_cfg_q    <= pwdata[15:0];
        hmng_pkg::AddrGridSpacing: spacing_cfg_q <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  // Row store ports. Reads go out one state ahead of the state that takes the data.
  always_comb begin
    mid_ra = c_q;
    up_ra  = c_q;
    unique case (state_q)
      ST_IDLE: begin
        mid_ra = in_data_i.cmd ? drain_col_q[CB-1:0] : col_q;
        up_ra  = mid_ra;
      end
      ST_RD1: begin
        mid_ra = c_q + CB'(1);
        up_ra  = c_q - CB'(1);
      end
      ST_RD2: mid_ra = c_q - CB'(1);
      default: ;
    endcase
  end

  always_comb begin
    mid_we = 1'b0;
    up_we  = 1'b0;
    mid_wa = c_q;
    mid_wd = sample_q;
    if (state_q == ST_IDLE && accept && !in_data_i.cmd && !draining_q && row_q == 16'd0) begin
      mid_we = 1'b1;
      mid_wa = col_q;
      mid_wd = in_data_i.height_sample;
    end else if (state_q == ST_RD3 && !drain_mode_q) begin
      mid_we = 1'b1;
      up_we  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_we) mid_mem[mid_wa] <= mid_wd;
    if (up_we) up_mem[c_q] <= ctr_q;
    mid_rd_q <= mid_mem[mid_ra];
    up_rd_q  <= up_mem[up_ra];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd ? draining_q : (!draining_q && row_q != 16'd0)) state_d = ST_RD1;
        end
      end
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_CALC;
      ST_CALC: state_d = ST_WAIT;
      ST_WAIT: if (norm_done) state_d = ST_EMIT;
      ST_EMIT: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      drain_col_q <= '0;
      draining_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // A new normal replaces one that leaves in the same cycle.
      if (state_q == ST_EMIT && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        if (in_data_i.cmd) begin
          if (draining_q) begin
            if (12'(drain_col_q) + 12'd1 >= 12'(cols)) begin
              draining_q  <= 1'b0;
              drain_col_q <= '0;
              row_q       <= '0;
              col_q       <= '0;
            end else begin
              drain_col_q <= drain_col_q + 11'd1;
            end
          end
        end else if (!draining_q) begin
          if (11'(col_q) + 11'd1 >= cols) begin
            col_q <= '0;
            if (17'(row_q) + 17'd1 >= 17'(rows)) begin
              draining_q  <= 1'b1;
              drain_col_q <= '0;
            end else begin
              row_q <= row_q + 16'd1;
            end
          end else begin
            col_q <= col_q + CB'(1);
          end
        end
      end
    end
  end

  // Transaction context and neighbour capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      drain_mode_q <= in_data_i.cmd;
      sample_q     <= in_data_i.height_sample;
      if (in_data_i.cmd) begin
        c_q         <= drain_col_q[CB-1:0];
        tag_row_q   <= row_q;
        tag_last_q  <= 12'(drain_col_q) + 12'd1 >= 12'(cols);
        has_left_q  <= drain_col_q[CB-1:0] != '0;
        has_right_q <= 12'(drain_col_q[CB-1:0]) + 12'd1 < 12'(cols);
        use_up_q    <= row_q != 16'd0;
      end else begin
        c_q         <= col_q;
        tag_row_q   <= row_q - 16'd1;
        tag_last_q  <= 1'b0;
        has_left_q  <= col_q != '0;
        has_right_q <= 12'(col_q) + 12'd1 < 12'(cols);
        use_up_q    <= row_q >= 16'd2;
      end
    end
    unique case (state_q)
      ST_RD1: begin
        ctr_q <= mid_rd_q;
        upv_q <= up_rd_q;
      end
      ST_RD2: begin
        right_q <= mid_rd_q;
        left_q  <= up_rd_q;
      end
      ST_RD3: if (drain_mode_q) left_q <= mid_rd_q;
      default: ;
    endcase
    if (state_q == ST_EMIT && state_d == ST_IDLE) begin
      out_q.normal_x      <= norm_res.x;
      out_q.normal_y      <= norm_res.y;
      out_q.normal_z      <= norm_res.z;
      out_q.out_row       <= tag_row_q;
      out_q.out_col       <= c_q;
      out_q.last_of_frame <= tag_last_q;
    end
  end

  // Missing neighbours at the grid edges take the centre sample. In the drain the
  // row below is absent, so the centre stands in for it too.
  always_comb begin
    norm_req.left    = has_left_q  ? left_q  : ctr_q;
    norm_req.right   = has_right_q ? right_q : ctr_q;
    norm_req.up      = use_up_q    ? upv_q   : ctr_q;
    norm_req.down    = drain_mode_q ? ctr_q  : sample_q;
    norm_req.spacing = spacing;
  end

  hmng_norm_unit u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_CALC),
    .req_i   (norm_req),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sim/heightmap_normal_generator_tb.sv
// Testbench for the heightmap normal generator: streams frames and checks every normal.
`timescale 1ns / 1ps

module heightmap_normal_generator_tb;

  // Meaning of the cmd bit of an input transaction.
  typedef enum logic {
    CmdSample = 1'b0,
    CmdDrain  = 1'b1
  } cmd_e;

  // Styles of height content for a frame.
  typedef enum int {
    HeightsRandom,
    HeightsExtreme,
    HeightsGentle
  } height_style_e;

  localparam int unsigned SettleCycles = 100;
  localparam int unsigned RandomItems  = 500;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  hmng_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  hmng_pkg::out_t out_data_o;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [3:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  heightmap_normal_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow of the block: configuration, row stores and sequencing counters.
  logic [10:0] grid_columns_q;
  logic [15:0] grid_rows_q;
  logic [24:0] grid_spacing_q;
  logic [15:0] upper_row[hmng_pkg::MaxColumns];
  logic [15:0] middle_row[hmng_pkg::MaxColumns];
  int unsigned column_count;
  int unsigned row_count;
  int unsigned drain_count;
  bit          draining;

  hmng_pkg::out_t expected_normals[$];
  int   errors;
  int   normals_checked;
  int   frames_sent;
  bit   idle_en;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Integer square root, bit by bit, as the block's normal unit does it.
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // One component in Q1.15: rounded quotient, saturated, sign applied.
  function automatic logic [15:0] q15_component(longint unsigned a, longint unsigned root,
                                                bit neg);
    longint unsigned q = ((a << 25) + (root >> 1)) / root;
    if (q > 32767) q = 32767;
    return neg ? 16'(17'h10000 - q) : 16'(q);
  endfunction

  // Unit normal of (-dx, 2*spacing, -dz) for one grid point.
  function automatic hmng_pkg::out_t normal_at(int unsigned row, int unsigned col,
                                               logic [15:0] up, logic [15:0] down,
                                               logic [15:0] left, logic [15:0] right,
                                               bit last);
    longint          dx = longint'(right) - longint'(left);
    longint          dz = longint'(up) - longint'(down);
    longint unsigned sp = (grid_spacing_q == 0) ? 1 : grid_spacing_q;
    longint unsigned ax = (dx < 0) ? -dx : dx;
    longint unsigned az = (dz < 0) ? -dz : dz;
    longint unsigned ay = sp * 2;
    longint unsigned mx;
    longint unsigned root;
    hmng_pkg::out_t  res;
    mx = (ax > ay) ? ax : ay;
    if (az > mx) mx = az;
    while (mx >= (64'd1 << 20)) begin
      mx >>= 1;
      ax >>= 1;
      ay >>= 1;
      az >>= 1;
    end
    root = isqrt((ax * ax + ay * ay + az * az) << 20);
    res.normal_x      = q15_component(ax, root, dx > 0);
    res.normal_y      = 15'(q15_component(ay, root, 1'b0));
    res.normal_z      = q15_component(az, root, dz > 0);
    res.out_row       = 16'(row);
    res.out_col       = col[hmng_pkg::ColBits-1:0];
    res.last_of_frame = last;
    return res;
  endfunction

  // Advances the shadow state by one accepted transaction; returns 1 when a normal is due.
  function automatic bit predict_normal(hmng_pkg::in_t item, output hmng_pkg::out_t res);
    int unsigned cols;
    int unsigned rows;
    int unsigned c;
    logic [15:0] ctr;
    logic [15:0] lft;
    logic [15:0] rgt;
    logic [15:0] upv;
    bit          got;
    cols = (grid_columns_q < 2) ? 2 :
           (grid_columns_q > hmng_pkg::MaxColumns) ? hmng_pkg::MaxColumns : grid_columns_q;
    rows = (grid_rows_q < 2) ? 2 : grid_rows_q;
    got  = 1'b0;
    res  = '0;
    if (item.cmd == CmdDrain) begin
      if (!draining) return 1'b0;
      c   = drain_count % hmng_pkg::MaxColumns;
      ctr = middle_row[c];
      lft = (c > 0) ? middle_row[c-1] : ctr;
      rgt = (c + 1 < cols) ? middle_row[c+1] : ctr;
      upv = (row_count >= 1) ? upper_row[c] : ctr;
      if (drain_count + 1 >= cols) begin
        res          = normal_at(row_count, c, upv, ctr, lft, rgt, 1'b1);
        draining     = 1'b0;
        drain_count  = 0;
        row_count    = 0;
        column_count = 0;
      end else begin
        res = normal_at(row_count, c, upv, ctr, lft, rgt, 1'b0);
        drain_count++;
      end
      return 1'b1;
    end
    if (draining) return 1'b0;
    c = column_count % hmng_pkg::MaxColumns;
    if (row_count >= 1) begin
      ctr = middle_row[c];
      lft = (c > 0) ? upper_row[c-1] : ctr;
      rgt = (c + 1 < cols) ? middle_row[c+1] : ctr;
      upv = (row_count >= 2) ? upper_row[c] : ctr;
      res = normal_at(row_count - 1, c, upv, item.height_sample, lft, rgt, 1'b0);
      got = 1'b1;
      upper_row[c] = ctr;
    end
    middle_row[c] = item.height_sample;
    if (column_count + 1 >= cols) begin
      column_count = 0;
      if (row_count + 1 >= rows) begin
        draining    = 1'b1;
        drain_count = 0;
      end else begin
        row_count++;
      end
    end else begin
      column_count++;
    end
    return got;
  endfunction

  // Sends one transaction after a random gap and records its expected normal.
  task automatic send_item(logic cmd, logic [15:0] height);
    int             gap;
    hmng_pkg::in_t  item;
    hmng_pkg::out_t res;
    item.cmd           = cmd;
    item.height_sample = height;
    gap = idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    if (predict_normal(item, res)) expected_normals = {expected_normals, res};
  endtask

  // Receiver: random stall before each transaction, then compare with the oldest expectation.
  initial begin : normal_checker
    int             stall;
    hmng_pkg::out_t got;
    hmng_pkg::out_t exp;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_en ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      got = out_data_o;
      @(posedge clk_i);
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected normal row %0d col %0d", $time, got.out_row, got.out_col);
        errors++;
      end else begin
        exp = expected_normals.pop_front();
        normals_checked++;
        if (got.normal_x !== exp.normal_x) begin
          $display("%0t: normal_x exp %0d got %0d", $time, exp.normal_x, got.normal_x);
          errors++;
        end
        if (got.normal_y !== exp.normal_y) begin
          $display("%0t: normal_y exp %0d got %0d", $time, exp.normal_y, got.normal_y);
          errors++;
        end
        if (got.normal_z !== exp.normal_z) begin
          $display("%0t: normal_z exp %0d got %0d", $time, exp.normal_z, got.normal_z);
          errors++;
        end
        if (got.out_row !== exp.out_row) begin
          $display("%0t: out_row exp %0d got %0d", $time, exp.out_row, got.out_row);
          errors++;
        end
        if (got.out_col !== exp.out_col) begin
          $display("%0t: out_col exp %0d got %0d", $time, exp.out_col, got.out_col);
          errors++;
        end
        if (got.last_of_frame !== exp.last_of_frame) begin
          $display("%0t: last_of_frame exp %0b got %0b", $time, exp.last_of_frame,
                   got.last_of_frame);
          errors++;
        end
      end
    end
  end

  // Stops input, waits for every expected normal, then lets the block finish any work.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write: setup cycle then access cycle; the shadow follows at the write edge.
  task automatic cfg_write(logic [3:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      hmng_pkg::AddrGridColumns: grid_columns_q = data[10:0];
      hmng_pkg::AddrGridRows:    grid_rows_q    = data[15:0];
      hmng_pkg::AddrGridSpacing: grid_spacing_q = data[24:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic cfg_read_check(logic [3:0] addr, logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: register %0h exp %0h got %0h", $time, addr, want, got);
      errors++;
    end
    @(posedge clk_i);
  endtask

  task automatic set_grid(int unsigned cols, int unsigned rows, int unsigned spacing);
    cfg_write(hmng_pkg::AddrGridColumns, cols);
    cfg_write(hmng_pkg::AddrGridRows, rows);
    cfg_write(hmng_pkg::AddrGridSpacing, spacing);
  endtask

  function automatic logic [15:0] pick_height(height_style_e style, logic [15:0] prev);
    case (style)
      HeightsExtreme: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      HeightsGentle:  return prev + 16'($urandom_range(0, 64)) - 16'd32;
      default:        return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sends drain ticks until the frame's last normal, with the odd ignored sample among them.
  task automatic flush_frame(int noise_pct);
    while (draining) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(CmdSample, 16'($urandom));
      else send_item(CmdDrain, 16'($urandom));
    end
  endtask

  // One whole frame of samples in a given style, stray drain ticks mixed in, then the flush.
  task automatic stream_frame(height_style_e style, int noise_pct, inout int counted);
    logic [15:0] h;
    h = 16'($urandom);
    do begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(CmdDrain, 16'($urandom));
      end else begin
        h = pick_height(style, h);
        send_item(CmdSample, h);
        counted++;
      end
    end while (!draining);
    while (draining) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(CmdSample, 16'($urandom));
      end else begin
        send_item(CmdDrain, 16'($urandom));
        counted++;
      end
    end
    frames_sent++;
  endtask

  // Reset values read back, then each register written and read.
  task automatic test_registers();
    cfg_read_check(hmng_pkg::AddrGridColumns, 32'(hmng_pkg::ColumnsReset));
    cfg_read_check(hmng_pkg::AddrGridRows, 32'(hmng_pkg::RowsReset));
    cfg_read_check(hmng_pkg::AddrGridSpacing, 32'(hmng_pkg::SpacingReset));
    set_grid(1024, 65535, 25'h1FFFFFF);
    cfg_read_check(hmng_pkg::AddrGridColumns, 32'd1024);
    cfg_read_check(hmng_pkg::AddrGridRows, 32'd65535);
    cfg_read_check(hmng_pkg::AddrGridSpacing, 32'h1FFFFFF);
  endtask

  // Tiny frames with full-scale steps, stray drains and samples, and clamped registers.
  task automatic test_directed();
    set_grid(3, 3, 0);
    send_item(CmdDrain, 16'h0000);
    for (int i = 0; i < 9; i++) send_item(CmdSample, (i % 2) ? 16'hFFFF : 16'h0000);
    send_item(CmdSample, 16'hFFFF);
    flush_frame(0);
    send_item(CmdDrain, 16'hFFFF);
    settle();
    // Register values below the minimum and the widest spacing.
    set_grid(0, 1, 25'h1FFFFFF);
    send_item(CmdSample, 16'hFFFF);
    send_item(CmdSample, 16'h0000);
    send_item(CmdSample, 16'h0000);
    send_item(CmdSample, 16'hFFFF);
    flush_frame(0);
    settle();
    frames_sent += 2;
  endtask

  // Rows lowered while a frame is under way: the frame ends with the row in progress.
  task automatic test_rows_mid_frame();
    set_grid(4, 6, 1);
    repeat (9) send_item(CmdSample, 16'($urandom));
    settle();
    cfg_write(hmng_pkg::AddrGridRows, 2);
    while (!draining) send_item(CmdSample, 16'($urandom));
    flush_frame(0);
    settle();
    frames_sent++;
  endtask

  // A wide row with the rows register below its minimum.
  task automatic test_wide_row();
    int counted;
    counted = 0;
    set_grid(96, 0, 16777216);
    stream_frame(HeightsRandom, 0, counted);
    settle();
  endtask

  // Random frames: mostly well formed, small grids, random spacing and height style.
  task automatic test_random_frames();
    int          counted;
    int unsigned spacing;
    counted = 0;
    while (counted < RandomItems) begin
      idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       spacing = $urandom_range(1, 4);
        1:       spacing = $urandom_range(0, 25'h1FFFFFF);
        2:       spacing = 1 << $urandom_range(0, 24);
        default: spacing = $urandom_range(1, 70000);
      endcase
      set_grid($urandom_range(0, 9), $urandom_range(0, 6), spacing);
      stream_frame(height_style_e'($urandom_range(0, 2)), $urandom_range(0, 8), counted);
      settle();
    end
    idle_en = 1'b1;
  endtask

  initial begin : run_limit
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_sequence
    errors          = 0;
    normals_checked = 0;
    frames_sent     = 0;
    idle_en         = 1'b1;
    grid_columns_q  = hmng_pkg::ColumnsReset;
    grid_rows_q     = hmng_pkg::RowsReset;
    grid_spacing_q  = hmng_pkg::SpacingReset;
    column_count    = 0;
    row_count       = 0;
    drain_count     = 0;
    draining        = 1'b0;
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_registers();
    test_directed();
    test_rows_mid_frame();
    test_wide_row();
    test_random_frames();
    settle();

    if (expected_normals.size() != 0) begin
      $display("%0t: %0d normals never arrived", $time, expected_normals.size());
      errors++;
    end
    $display("Streamed %0d frames, from 2x2 grids up to a 96-column row, and checked %0d normals.",
             frames_sent, normals_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hmng_pkg.sv
rtl/hmng_norm_unit.sv
rtl/heightmap_normal_generator.sv
sim/heightmap_normal_generator_tb.sv
